[hdl/msce_pkg.sv]
// ----------------------------------------------------------------------------
// msce_pkg - shared types for the multi-axis step count engine
// Command codes, sequencer states and the request and response records of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package msce_pkg;

  // Fixed field widths of the command and result words.
  localparam int MASK_W   = 32;
  localparam int AMOUNT_W = 32;
  localparam int ID_W     = 8;
  localparam int COUNT_W  = 31;
  localparam int MODE_W   = 3;

  // Saturated step count for the most negative amount.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE     = 3'd0,
    MODE_STOP_ONE = 3'd1,
    MODE_STOP_ALL = 3'd2,
    MODE_TICK     = 3'd3,
    MODE_QUERY    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_TICK,
    S_QUERY,
    S_RESP
  } state_t;

  typedef enum logic {
    ALU_NEG,
    ALU_DEC
  } alu_op_t;

  typedef struct packed {
    alu_op_t               op;
    logic [AMOUNT_W-1:0]   operand;
  } alu_req_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0]   diff;
    logic                  diff_zero;
    logic                  operand_nonzero;
  } alu_rsp_t;

endpackage

[hdl/msce_ram.sv]
// ----------------------------------------------------------------------------
// msce_ram - generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module msce_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/msce_alu.sv]
// ----------------------------------------------------------------------------
// msce_alu - shared subtractor of the step count engine
// Negates a step amount when a move is decoded and decrements one counter per
// cycle during a tick sweep.
// ----------------------------------------------------------------------------
module msce_alu (
  input  msce_pkg::alu_req_t req,
  output msce_pkg::alu_rsp_t rsp
);

  logic [msce_pkg::AMOUNT_W-1:0] lhs;
  logic [msce_pkg::AMOUNT_W-1:0] rhs;

  always_comb begin
    if (req.op == msce_pkg::ALU_NEG) begin
      lhs = '0;
      rhs = req.operand;
    end else begin
      lhs = req.operand;
      rhs = msce_pkg::AMOUNT_W'(1);
    end
    rsp.diff            = lhs - rhs;
    rsp.diff_zero       = (rsp.diff == '0);
    rsp.operand_nonzero = (req.operand != '0);
  end

endmodule

[hdl/multi_axis_step_count_engine_core.sv]
// ----------------------------------------------------------------------------
// multi_axis_step_count_engine_core - step counters for motors on one pulse
// Command in, one status word out per command, with a small sequencer that
// walks the counter RAM through a single shared subtractor.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and holds s_tready low during
// reset and until the command has been handed to the output register. The
// word is accepted in the idle state and decoded in the decode state, and the
// result is loaded in the response state. A move sweeps the counter RAM once,
// stepping one motor per cycle and writing those in the mask. A step tick
// reads, decrements and writes back one counter per cycle through the shared
// subtractor. Because the RAM read is registered, the last counter is handled
// in the cycle after its address. A query adds a state for the RAM read. Stop
// one, stop all, a query with a bad index, a move that is rejected or carries
// no steps, and the unused codes go straight from decode to the result.
// Reset needs no clearing pass: a valid bit per motor marks counters that
// have been written since reset or since they were last stopped, and a
// counter without it reads as zero. If the previous result has not been taken
// the block waits with its new result until the output register is free.
// ----------------------------------------------------------------------------
module multi_axis_step_count_engine_core #(
  parameter int MOTOR_COUNT = 32
) (
  input  logic         clk,
  input  logic         rst,
  // Command words.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata, lowest bit up: motor_mask[31:0], step_amount[63:32],
  // direction[64], motor_index[72:65], zero fill[79:73].
  input  logic [79:0]  s_tdata,
  // tuser: mode[2:0].
  input  logic [2:0]   s_tuser,
  // Result words.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata, lowest bit up: active_mask[31:0], direction_mask[63:32],
  // pulse_running[64], finished_mask[96:65], remaining_steps[127:97].
  output logic [127:0] m_tdata,
  // tuser: status[0].
  output logic [0:0]   m_tuser
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [msce_pkg::MASK_W-1:0] VALID_MOTORS =
    msce_pkg::MASK_W'((64'd1 << MOTOR_COUNT) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MOTOR_COUNT - 1);

  msce_pkg::state_t state;
  msce_pkg::state_t state_next;

  // Captured command.
  msce_pkg::mode_t                 mode;
  logic [msce_pkg::MASK_W-1:0]     mask;
  logic [msce_pkg::AMOUNT_W-1:0]   amount;
  logic                            dir;
  logic [msce_pkg::ID_W-1:0]       id;
  logic [msce_pkg::COUNT_W-1:0]    mag;

  // Motor state kept in flip-flops.
  logic [msce_pkg::MASK_W-1:0]     running;
  logic [msce_pkg::MASK_W-1:0]     dirs;
  logic [MOTOR_COUNT-1:0]          valid;

  // Result being built.
  logic                            status;
  logic [msce_pkg::MASK_W-1:0]     finished;
  logic [msce_pkg::COUNT_W-1:0]    remaining;

  // Sweep control.
  logic [CNT_W-1:0]                idx;
  logic [IDX_W-1:0]                pidx;
  logic                            rd_pend;

  logic [IDX_W-1:0]                idx_lo;
  logic [IDX_W-1:0]                id_lo;
  logic                            id_bad;
  logic                            out_free;
  logic                            sweep_done;

  // RAM and subtractor connections.
  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [msce_pkg::COUNT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]                ram_raddr;
  logic [msce_pkg::COUNT_W-1:0]    ram_rdata;
  msce_pkg::alu_req_t              alu_req;
  msce_pkg::alu_rsp_t              alu_rsp;

  logic [msce_pkg::COUNT_W-1:0]    cur_count;
  logic [msce_pkg::COUNT_W-1:0]    neg_mag;
  logic                            do_dec;

  assign idx_lo     = idx[IDX_W-1:0];
  assign id_lo      = id[IDX_W-1:0];
  assign id_bad     = (id >= msce_pkg::ID_W'(MOTOR_COUNT));
  assign out_free   = !m_tvalid || m_tready;
  assign sweep_done = (idx == CNT_W'(MOTOR_COUNT));
  assign s_tready   = (state == msce_pkg::S_IDLE) && !rst;

  msce_ram #(
    .WIDTH (msce_pkg::COUNT_W),
    .DEPTH (MOTOR_COUNT)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msce_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // The counter seen during a tick is zero unless it has been written.
  assign cur_count = valid[pidx] ? ram_rdata : '0;
  // A positive amount is its own magnitude; a negative one is negated by the
  // subtractor, and a magnitude of two to the thirty-first does not fit and
  // saturates.
  assign neg_mag   = !amount[msce_pkg::AMOUNT_W-1] ? amount[msce_pkg::COUNT_W-1:0]
                   : alu_rsp.diff[msce_pkg::AMOUNT_W-1] ? msce_pkg::COUNT_MAX
                   : alu_rsp.diff[msce_pkg::COUNT_W-1:0];
  // A running motor whose count is already zero is left alone.
  assign do_dec    = rd_pend && running[pidx] && alu_rsp.operand_nonzero;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      msce_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = msce_pkg::S_DECODE;
        end
      end
      msce_pkg::S_DECODE: begin
        unique case (mode)
          msce_pkg::MODE_MOVE: begin
            if (mask != '0 && neg_mag != '0) begin
              state_next = msce_pkg::S_MOVE;
            end else begin
              state_next = msce_pkg::S_RESP;
            end
          end
          msce_pkg::MODE_TICK: state_next = msce_pkg::S_TICK;
          msce_pkg::MODE_QUERY: begin
            state_next = id_bad ? msce_pkg::S_RESP : msce_pkg::S_QUERY;
          end
          default: state_next = msce_pkg::S_RESP;
        endcase
      end
      msce_pkg::S_MOVE: begin
        if (idx_lo == LAST_IDX) begin
          state_next = msce_pkg::S_RESP;
        end
      end
      msce_pkg::S_TICK: begin
        if (sweep_done) begin
          state_next = msce_pkg::S_RESP;
        end
      end
      msce_pkg::S_QUERY: state_next = msce_pkg::S_RESP;
      msce_pkg::S_RESP: begin
        if (out_free) begin
          state_next = msce_pkg::S_IDLE;
        end
      end
      default: state_next = msce_pkg::S_IDLE;
    endcase
  end

  // RAM and subtractor control.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = pidx;
    ram_wdata       = alu_rsp.diff[msce_pkg::COUNT_W-1:0];
    ram_raddr       = idx_lo;
    alu_req.op      = msce_pkg::ALU_DEC;
    alu_req.operand = {1'b0, cur_count};
    unique case (state)
      msce_pkg::S_DECODE: begin
        alu_req.op      = msce_pkg::ALU_NEG;
        alu_req.operand = amount;
        ram_raddr       = id_lo;
      end
      msce_pkg::S_MOVE: begin
        ram_we    = mask[idx_lo];
        ram_waddr = idx_lo;
        ram_wdata = mag;
      end
      msce_pkg::S_TICK: begin
        ram_we = do_dec;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= msce_pkg::S_IDLE;
      running  <= '0;
      dirs     <= '0;
      valid    <= '0;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      state <= state_next;
      // A new result word is loaded as soon as the output register is free.
      if (state == msce_pkg::S_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        msce_pkg::S_DECODE: begin
          unique case (mode)
            msce_pkg::MODE_MOVE: begin
              if (mask != '0 && neg_mag != '0) begin
                running <= running | (mask & VALID_MOTORS);
                if (dir) begin
                  dirs <= dirs | (mask & VALID_MOTORS);
                end else begin
                  dirs <= dirs & ~(mask & VALID_MOTORS);
                end
              end
            end
            msce_pkg::MODE_STOP_ONE: begin
              if (!id_bad) begin
                valid[id_lo]   <= 1'b0;
                running[id_lo] <= 1'b0;
              end
            end
            msce_pkg::MODE_STOP_ALL: begin
              valid   <= '0;
              running <= '0;
            end
            default: begin
            end
          endcase
          rd_pend <= 1'b0;
        end
        msce_pkg::S_MOVE: begin
          if (mask[idx_lo]) begin
            valid[idx_lo] <= 1'b1;
          end
        end
        msce_pkg::S_TICK: begin
          rd_pend <= !sweep_done;
          if (do_dec && alu_rsp.diff_zero) begin
            running[pidx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      msce_pkg::S_IDLE: begin
        if (s_tvalid) begin
          mode      <= msce_pkg::mode_t'(s_tuser);
          mask      <= s_tdata[31:0];
          amount    <= s_tdata[63:32];
          dir       <= s_tdata[64];
          id        <= s_tdata[72:65];
          status    <= 1'b0;
          finished  <= '0;
          remaining <= '0;
        end
      end
      msce_pkg::S_DECODE: begin
        mag <= neg_mag;
        idx <= '0;
        if (mode == msce_pkg::MODE_MOVE && mask == '0) begin
          status <= 1'b1;
        end
        if ((mode == msce_pkg::MODE_STOP_ONE || mode == msce_pkg::MODE_QUERY) && id_bad) begin
          status <= 1'b1;
        end
      end
      msce_pkg::S_MOVE: begin
        idx <= idx + CNT_W'(1);
      end
      msce_pkg::S_TICK: begin
        if (!sweep_done) begin
          idx  <= idx + CNT_W'(1);
          pidx <= idx_lo;
        end
        if (do_dec && alu_rsp.diff_zero) begin
          finished[pidx] <= 1'b1;
        end
      end
      msce_pkg::S_QUERY: begin
        remaining <= valid[id_lo] ? ram_rdata : '0;
      end
      msce_pkg::S_RESP: begin
        if (out_free) begin
          m_tdata <= {remaining, finished, (running != '0), dirs, running};
          m_tuser <= status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
